// ===== rtl/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

    localparam int unsigned FRAME_BYTES   = 25;
    localparam int unsigned NUM_CH        = 18;
    localparam int unsigned NUM_ANA_CH    = 16;
    localparam int unsigned CH_W          = 11;
    localparam int unsigned IDX_W         = 5;
    localparam int unsigned ANA_IDX_W     = 4;
    localparam int unsigned POS_W         = 5;
    localparam int unsigned ACC_W         = 18;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam logic [7:0]  START_BYTE    = 8'h0f;
    localparam logic [7:0]  FLAG_DIG16    = 8'h01;
    localparam logic [7:0]  FLAG_DIG17    = 8'h02;
    localparam logic [7:0]  FLAG_LOSS     = 8'h04;
    localparam logic [7:0]  FLAG_FAILSAFE = 8'h08;

    localparam logic [POS_W-1:0] POS_LAST_DATA = 5'd22;
    localparam logic [POS_W-1:0] POS_FLAGS     = 5'd23;
    localparam logic [POS_W-1:0] POS_FOOTER    = 5'd24;
    localparam logic [POS_W-1:0] POS_FULL      = 5'd25;

    localparam logic [IDX_W-1:0] LAST_CH     = 5'd17;
    localparam logic [IDX_W-1:0] FIRST_DIG   = 5'd16;
    localparam logic [CH_W-1:0]  CH_MAX      = 11'h7ff;

    localparam logic [15:0]      GAP_THR_RST = 16'd2000;
    localparam logic [CH_W-1:0]  DIG_HI_RST  = 11'd1807;
    localparam logic [CH_W-1:0]  DIG_LO_RST  = 11'd240;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIG_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIG_LO  = 2'd2;

    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_FAILSAFE = 2'd2;
    localparam logic [1:0] ST_LOST     = 2'd3;

    typedef struct packed {
        logic        func;
        logic [7:0]  byte_in;
        logic [15:0] elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] chan_index;
        logic [CH_W-1:0]  chan_value;
        logic [31:0]      frames_good;
        logic [CH_W-1:0]  max_spread;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic       done;
        logic [1:0] status;
    } t_frm_evt;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  value;
    } t_walk_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sbus_frame_receiver_top.sv =====
`default_nettype none

// Serial bus frame receiver. Every request carries a received byte with the
// microseconds since the previous one, or a clear of the min/max tracking. An
// ordinary byte or a clear is accepted and its single pending result sits in the
// output register from the next cycle, so such requests can follow back to back
// while results are taken. The byte that completes a 25-byte frame yields 18
// channel results: a clean frame first walks the min/max table, reading one entry
// per cycle and writing it back the cycle after, then the results leave the
// channel store at one per cycle behind a registered read while the output is not
// stalled. No new request is accepted until the last result of a frame has entered
// the output register. A request is only accepted when the block is idle and the
// output register is empty or its result is taken in the same cycle. Write the
// configuration only while nothing is in flight.
module sbus_frame_receiver_top
    import sfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [15:0]      r_gap_thr;
    logic [CH_W-1:0]  r_dig_hi;
    logic [CH_W-1:0]  r_dig_lo;

    logic [IDX_W-1:0] r_k;
    logic             r_iss_done;
    logic             r_dv;
    logic [IDX_W-1:0] r_dk;
    logic [1:0]       r_status;
    logic [31:0]      r_good;

    logic             r_ov;
    logic [1:0]       r_ost;
    logic [IDX_W-1:0] r_oidx;
    logic [CH_W-1:0]  r_oval;
    logic             r_olast;

    logic             w_out_free;
    logic             w_accept;
    logic             w_step;
    logic             w_clear;
    logic             w_walk_go;
    logic             w_emit_go;
    logic             w_issue;
    logic             w_out_load;
    logic             w_consume;
    logic             w_walk_done;
    logic             w_emit_done;
    logic [CH_W-1:0]  w_dval;

    t_frm_evt         w_evt;
    t_walk_req        w_walk;
    logic [1:0]       w_dig_flags;
    logic [CH_W-1:0]  w_store_rd;
    logic [CH_W-1:0]  w_spread;

    assign w_out_free = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_step     = w_accept && !i_in_data.func;
    assign w_clear    = w_accept && i_in_data.func;
    assign w_walk_go  = w_step && w_evt.done && (w_evt.status == ST_OK);
    assign w_emit_go  = w_step && w_evt.done && (w_evt.status != ST_OK);

    sfr_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (i_in_data.byte_in),
        .i_elapsed   (i_in_data.elapsed_us),
        .i_gap_thr   (r_gap_thr),
        .i_rd_en     (w_issue),
        .i_rd_addr   (r_k[ANA_IDX_W-1:0]),
        .o_evt       (w_evt),
        .o_dig_flags (w_dig_flags),
        .o_rd_data   (w_store_rd)
    );

    sfr_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_clear),
        .i_rd_en     (w_issue),
        .i_rd_addr   (r_k),
        .i_walk      (w_walk),
        .i_walk_done (w_walk_done),
        .o_spread    (w_spread)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_walk_go) begin
                    n_state = S_WALK;
                end else if (w_emit_go) begin
                    n_state = S_EMIT;
                end
            end
            S_WALK: begin
                if (w_walk_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_out_load = (r_state == S_EMIT) && r_dv && w_out_free;
        // in emit, read ahead only when the read register will be free
        w_issue    = (r_state != S_IDLE) && !r_iss_done
                     && ((r_state == S_WALK) || !r_dv || w_out_load);
        w_consume  = (r_state == S_WALK) ? r_dv : w_out_load;
        w_walk_done = (r_state == S_WALK) && r_dv && (r_dk == LAST_CH);
        w_emit_done = w_out_load && (r_dk == LAST_CH);
        if (r_dk >= FIRST_DIG) begin
            w_dval = w_dig_flags[r_dk[0]] ? r_dig_hi : r_dig_lo;
        end else begin
            w_dval = w_store_rd;
        end
        w_walk.valid = (r_state == S_WALK) && r_dv;
        w_walk.idx   = r_dk;
        w_walk.value = w_dval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gap_thr  <= GAP_THR_RST;
            r_dig_hi   <= DIG_HI_RST;
            r_dig_lo   <= DIG_LO_RST;
            r_k        <= '0;
            r_iss_done <= 1'b0;
            r_dv       <= 1'b0;
            r_good     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAP_THR: r_gap_thr <= i_cfg_data;
                    CFG_DIG_HI:  r_dig_hi  <= i_cfg_data[CH_W-1:0];
                    CFG_DIG_LO:  r_dig_lo  <= i_cfg_data[CH_W-1:0];
                    default: ;
                endcase
            end

            if (w_walk_go || w_emit_go || w_walk_done) begin
                r_k        <= '0;
                r_iss_done <= 1'b0;
            end else if (w_issue) begin
                if (r_k == LAST_CH) begin
                    r_iss_done <= 1'b1;
                end else begin
                    r_k <= r_k + 5'd1;
                end
            end
            r_dv <= w_issue || (r_dv && !w_consume);

            if (w_walk_go) begin
                r_good <= r_good + 32'd1;
            end

            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (w_accept && !w_walk_go && !w_emit_go) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_dk <= r_k;
        end
        if (w_walk_go || w_emit_go) begin
            r_status <= w_evt.status;
        end
        if (w_out_load) begin
            r_ost   <= r_status;
            r_oidx  <= r_dk;
            r_oval  <= w_dval;
            r_olast <= (r_dk == LAST_CH);
        end else if (w_accept) begin
            r_ost   <= ST_PENDING;
            r_oidx  <= '0;
            r_oval  <= '0;
            r_olast <= 1'b1;
        end
    end

    assign o_out_valid            = r_ov;
    assign o_out_data.status      = r_ost;
    assign o_out_data.chan_index  = r_oidx;
    assign o_out_data.chan_value  = r_oval;
    assign o_out_data.frames_good = r_good;
    assign o_out_data.max_spread  = w_spread;
    assign o_out_data.last        = r_olast;

`ifndef SYNTHESIS
    a_walk_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !r_ov)
        else $error("result presented during min/max walk");
    a_pending_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_ost == ST_PENDING)) |-> (r_olast && (r_oidx == '0) && (r_oval == '0)))
        else $error("malformed pending result");
    a_good_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_good) |-> $past(w_walk_go))
        else $error("frame count moved without a clean frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/sfr_framer.sv =====
`default_nettype none

module sfr_framer
    import sfr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [7:0]           i_byte,
    input  wire logic [15:0]          i_elapsed,
    input  wire logic [15:0]          i_gap_thr,
    input  wire logic                 i_rd_en,
    input  wire logic [ANA_IDX_W-1:0] i_rd_addr,
    output t_frm_evt                  o_evt,
    output logic [1:0]                o_dig_flags,
    output logic [CH_W-1:0]           o_rd_data
);

    logic [CH_W-1:0] r_mem [0:NUM_ANA_CH-1];

    logic [POS_W-1:0]     r_pos,   n_pos;
    logic                 r_lock,  n_lock;
    logic [ACC_W-1:0]     r_acc,   n_acc;
    logic [POS_W-1:0]     r_cnt,   n_cnt;
    logic [ANA_IDX_W-1:0] r_ch,    n_ch;
    logic [7:0]           r_flags, n_flags;
    logic [CH_W-1:0]      r_rd_data;

    logic                 w_gap;
    logic [POS_W-1:0]     w_pos_e;
    logic                 w_lock_e;
    logic [ACC_W-1:0]     w_wide;
    logic [POS_W-1:0]     w_sum;
    logic                 w_wr_en;
    logic                 w_done;

    assign w_gap    = i_elapsed > i_gap_thr;
    assign w_pos_e  = w_gap ? '0 : r_pos;
    assign w_lock_e = w_gap ? 1'b0 : r_lock;
    assign w_wide   = r_acc | (ACC_W'(i_byte) << r_cnt);
    assign w_sum    = r_cnt + 5'd8;

    always_comb begin
        n_pos   = r_pos;
        n_lock  = r_lock;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_ch    = r_ch;
        n_flags = r_flags;
        w_wr_en = 1'b0;
        w_done  = 1'b0;
        if (i_step) begin
            n_pos  = w_pos_e;
            n_lock = w_lock_e;
            if (!w_lock_e) begin
                if (w_pos_e == '0) begin
                    // drop anything but the start byte
                    if (i_byte == START_BYTE) begin
                        n_pos = 5'd1;
                        n_acc = '0;
                        n_cnt = '0;
                        n_ch  = '0;
                    end
                end else if (w_pos_e < POS_FULL) begin
                    n_pos = w_pos_e + 5'd1;
                    if (w_pos_e <= POS_LAST_DATA) begin
                        // pack bytes LSB first, peel off an 11-bit channel when ready
                        if (w_sum >= POS_W'(CH_W)) begin
                            w_wr_en = 1'b1;
                            n_acc   = w_wide >> CH_W;
                            n_cnt   = w_sum - POS_W'(CH_W);
                            n_ch    = r_ch + 4'd1;
                        end else begin
                            n_acc = w_wide;
                            n_cnt = w_sum;
                        end
                    end else if (w_pos_e == POS_FLAGS) begin
                        n_flags = i_byte;
                    end
                    w_done = (w_pos_e == POS_FOOTER);
                end else begin
                    // overrun after a full frame: lock until the next gap
                    n_pos  = '0;
                    n_lock = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_lock <= 1'b0;
            r_cnt  <= '0;
            r_ch   <= '0;
        end else begin
            r_pos  <= n_pos;
            r_lock <= n_lock;
            r_cnt  <= n_cnt;
            r_ch   <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_flags <= n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_ch] <= w_wide[CH_W-1:0];
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_comb begin
        o_evt.done = w_done;
        if ((r_flags & FLAG_FAILSAFE) != 8'h00) begin
            o_evt.status = ST_FAILSAFE;
        end else if ((r_flags & FLAG_LOSS) != 8'h00) begin
            o_evt.status = ST_LOST;
        end else begin
            o_evt.status = ST_OK;
        end
    end

    assign o_dig_flags = {(r_flags & FLAG_DIG17) != 8'h00, (r_flags & FLAG_DIG16) != 8'h00};
    assign o_rd_data   = r_rd_data;

`ifndef SYNTHESIS
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 5'd10) && (r_pos <= POS_FULL))
        else $error("framer bit count or position out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/sfr_tracker.sv =====
`default_nettype none

module sfr_tracker
    import sfr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    input  wire t_walk_req        i_walk,
    input  wire logic             i_walk_done,
    output logic [CH_W-1:0]       o_spread
);

    logic [2*CH_W-1:0] r_mem [0:NUM_CH-1];
    logic [2*CH_W-1:0] r_rd_data;
    logic              r_mm_valid;
    logic [CH_W-1:0]   r_spread;

    logic [CH_W-1:0]   w_old_min;
    logic [CH_W-1:0]   w_old_max;
    logic [CH_W-1:0]   w_new_min;
    logic [CH_W-1:0]   w_new_max;
    logic [CH_W-1:0]   w_cand;

    // untouched table reads as min all-ones, max zero
    assign w_old_min = r_mm_valid ? r_rd_data[2*CH_W-1:CH_W] : CH_MAX;
    assign w_old_max = r_mm_valid ? r_rd_data[CH_W-1:0] : '0;
    assign w_new_min = (i_walk.value < w_old_min) ? i_walk.value : w_old_min;
    assign w_new_max = (i_walk.value > w_old_max) ? i_walk.value : w_old_max;
    assign w_cand    = w_new_max - w_new_min;

    always_ff @(posedge i_clk) begin
        if (i_walk.valid) begin
            r_mem[i_walk.idx] <= {w_new_min, w_new_max};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_valid <= 1'b0;
            r_spread   <= '0;
        end else if (i_clear) begin
            r_mm_valid <= 1'b0;
            r_spread   <= '0;
        end else begin
            if (i_walk_done) begin
                r_mm_valid <= 1'b1;
            end
            // per-channel spread only grows, so a running maximum suffices
            if (i_walk.valid && (w_cand > r_spread)) begin
                r_spread <= w_cand;
            end
        end
    end

    assign o_spread = r_spread;

`ifndef SYNTHESIS
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_walk.valid |-> (w_new_max >= w_new_min))
        else $error("tracker min above max");
    a_spread_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_spread == '0) && !r_mm_valid)
        else $error("tracker spread not cleared");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_sbus_frame_receiver_top.sv =====
`timescale 1ns / 1ps

module tb_sbus_frame_receiver_top;
    import sfr_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 12;

    // Predicts channel results for each accepted request and checks them in order.
    class channel_tracker;
        logic [15:0]     gap_limit;
        logic [CH_W-1:0] dig_high;
        logic [CH_W-1:0] dig_low;
        int              position;
        bit              locked;
        logic [7:0]      frame_buf [FRAME_BYTES];
        logic [CH_W-1:0] chan_lo [NUM_CH];
        logic [CH_W-1:0] chan_hi [NUM_CH];
        bit              tracking;
        logic [31:0]     good_frames;
        t_out_item       due [$];
        int              errors;
        int              checked;

        function new();
            gap_limit   = GAP_THR_RST;
            dig_high    = DIG_HI_RST;
            dig_low     = DIG_LO_RST;
            position    = 0;
            locked      = 0;
            good_frames = '0;
            errors      = 0;
            checked     = 0;
            clear_tracking();
        endfunction

        function void clear_tracking();
            for (int i = 0; i < NUM_CH; i++) begin
                chan_lo[i] = CH_MAX;
                chan_hi[i] = '0;
            end
            tracking = 0;
        endfunction

        function logic [CH_W-1:0] max_spread();
            logic [CH_W-1:0] best;
            logic [CH_W-1:0] d;
            best = '0;
            if (tracking) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    d = chan_hi[i] - chan_lo[i];
                    if (d > best) best = d;
                end
            end
            return best;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_GAP_THR: gap_limit = value;
                CFG_DIG_HI:  dig_high  = value[CH_W-1:0];
                CFG_DIG_LO:  dig_low   = value[CH_W-1:0];
                default: ;
            endcase
        endfunction

        function void queue_result(logic [1:0] status, int idx, logic [CH_W-1:0] value,
                                   bit last);
            t_out_item r;
            r.status      = status;
            r.chan_index  = idx[IDX_W-1:0];
            r.chan_value  = value;
            r.frames_good = good_frames;
            r.max_spread  = max_spread();
            r.last        = last;
            due.push_back(r);
        endfunction

        function void decode_frame();
            logic [23:0]     word;
            logic [CH_W-1:0] vals [NUM_CH];
            logic [7:0]      flags;
            logic [1:0]      st;
            int              bitpos;
            int              at;
            flags = frame_buf[POS_FLAGS];
            for (int i = 0; i < NUM_ANA_CH; i++) begin
                bitpos  = 11 * i;
                at      = 1 + bitpos / 8;
                word    = {frame_buf[at + 2], frame_buf[at + 1], frame_buf[at]};
                word    = word >> (bitpos % 8);
                vals[i] = word[CH_W-1:0];
            end
            vals[16] = ((flags & FLAG_DIG16) != 0) ? dig_high : dig_low;
            vals[17] = ((flags & FLAG_DIG17) != 0) ? dig_high : dig_low;
            // failsafe wins over signal loss; neither counts nor tracks
            if ((flags & FLAG_FAILSAFE) != 0) begin
                st = ST_FAILSAFE;
            end else if ((flags & FLAG_LOSS) != 0) begin
                st = ST_LOST;
            end else begin
                st = ST_OK;
                good_frames++;
                for (int i = 0; i < NUM_CH; i++) begin
                    if (vals[i] < chan_lo[i]) chan_lo[i] = vals[i];
                    if (vals[i] > chan_hi[i]) chan_hi[i] = vals[i];
                end
                tracking = 1;
            end
            for (int i = 0; i < NUM_CH; i++) begin
                queue_result(st, i, vals[i], i == NUM_CH - 1);
            end
        endfunction

        function void note_request(t_in_item req);
            if (req.func) begin
                clear_tracking();
                queue_result(ST_PENDING, 0, '0, 1'b1);
                return;
            end
            if (req.elapsed_us > gap_limit) begin
                position = 0;
                locked   = 0;
            end
            if (!locked) begin
                if (position == 0) begin
                    if (req.byte_in == START_BYTE) begin
                        frame_buf[0] = req.byte_in;
                        position     = 1;
                    end
                end else if (position < FRAME_BYTES) begin
                    frame_buf[position] = req.byte_in;
                    position++;
                    if (position == FRAME_BYTES) begin
                        decode_frame();
                        return;
                    end
                end else begin
                    // byte beyond a full frame with no gap
                    position = 0;
                    locked   = 1;
                end
            end
            queue_result(ST_PENDING, 0, '0, 1'b1);
        endfunction

        function void report_field(string name, longint unsigned want, longint unsigned got);
            $display("%0t: result %0d %s mismatch, expected %0d actual %0d",
                     $time, checked, name, want, got);
            errors++;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.status != want.status)
                report_field("status", want.status, got.status);
            if (got.chan_index != want.chan_index)
                report_field("chan_index", want.chan_index, got.chan_index);
            if (got.chan_value != want.chan_value)
                report_field("chan_value", want.chan_value, got.chan_value);
            if (got.frames_good != want.frames_good)
                report_field("frames_good", want.frames_good, got.frames_good);
            if (got.max_spread != want.max_spread)
                report_field("max_spread", want.max_spread, got.max_spread);
            if (got.last != want.last)
                report_field("last", want.last, got.last);
            checked++;
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    channel_tracker tracker;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             sent_items;
    int             quiet_cycles;

    sbus_frame_receiver_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) tracker.note_request(i_in_data);
            if (o_out_valid && i_out_ready) tracker.check_result(o_out_data);
        end
    end

    // End the run if nothing moves on either channel for too long
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [15:0] us);
        t_in_item req;
        req.func       = 1'b0;
        req.byte_in    = b;
        req.elapsed_us = us;
        send_request(req);
    endtask

    task automatic send_clear();
        t_in_item req;
        req.func       = 1'b1;
        req.byte_in    = 8'($urandom_range(255));
        req.elapsed_us = 16'($urandom_range(16'hffff));
        send_request(req);
    endtask

    function automatic logic [15:0] gap_us();
        if (tracker.gap_limit == 16'hffff) return 16'hffff;
        if ($urandom_range(3) == 0) return tracker.gap_limit + 16'd1;
        return 16'($urandom_range(16'hffff, tracker.gap_limit + 1));
    endfunction

    function automatic logic [15:0] in_frame_us();
        if ($urandom_range(7) == 0) return tracker.gap_limit;
        return 16'($urandom_range(tracker.gap_limit));
    endfunction

    function automatic logic [7:0] random_flags();
        logic [7:0] f;
        f = 8'($urandom_range(255));
        if ($urandom_range(2) != 0) f = f & ~(FLAG_LOSS | FLAG_FAILSAFE);
        return f;
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // fill below zero gives random body bytes and the odd clear request mid-frame
    task automatic send_frame(input logic [15:0] lead_us, input int fill,
                              input logic [7:0] flags);
        logic [7:0] b;
        send_byte(START_BYTE, lead_us);
        for (int k = 1; k < FRAME_BYTES; k++) begin
            if (fill < 0 && $urandom_range(24) == 0) send_clear();
            if (k == POS_FLAGS) b = flags;
            else if (fill >= 0) b = fill[7:0];
            else b = random_byte();
            send_byte(b, in_frame_us());
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(4, 1);
        repeat (n) begin
            send_byte(($urandom_range(3) == 0) ? START_BYTE : random_byte(),
                      16'($urandom_range(16'hffff)));
        end
    endtask

    task automatic send_sequence();
        int kind;
        int n;
        kind = $urandom_range(9);
        if (kind < 6) begin
            // with no gap possible, a frame can only start from a clean position
            if (tracker.gap_limit == 16'hffff && (tracker.position != 0 || tracker.locked))
                send_noise();
            else
                send_frame(gap_us(), -1, random_flags());
        end else if (kind == 6) begin
            send_clear();
        end else if (kind == 7) begin
            send_noise();
        end else if (kind == 8) begin
            send_byte(START_BYTE, gap_us());
            n = $urandom_range(22, 1);
            repeat (n) send_byte(random_byte(), in_frame_us());
        end else begin
            send_frame(gap_us(), -1, random_flags());
            n = $urandom_range(3, 1);
            repeat (n) send_byte(random_byte(), in_frame_us());
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        // let the monitor note the last request before looking at the queue
        @(posedge i_clk);
        while (tracker.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] thr, input logic [CH_W-1:0] hi,
                                  input logic [CH_W-1:0] lo);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_GAP_THR;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DIG_HI;
        i_cfg_data <= CFG_DATA_W'(hi);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DIG_LO;
        i_cfg_data <= CFG_DATA_W'(lo);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_register(CFG_GAP_THR, thr);
        tracker.set_register(CFG_DIG_HI, CFG_DATA_W'(hi));
        tracker.set_register(CFG_DIG_LO, CFG_DATA_W'(lo));
    endtask

    initial begin
        int         start_count;
        logic [7:0] b;
        tracker        = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_items     = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_GAP_THR;
        i_cfg_data     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on reset settings
        send_clear();
        send_byte(8'hff, 16'd0);
        send_frame(16'hffff, 8'hff, FLAG_DIG16 | FLAG_DIG17);
        send_byte(8'h00, GAP_THR_RST);
        send_byte(START_BYTE, 16'd0);
        send_frame(16'hffff, 8'h55, FLAG_FAILSAFE | FLAG_LOSS);
        send_clear();

        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: begin
                    apply_settings(16'd0, CH_MAX, '0);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    apply_settings(16'hffff, '0, CH_MAX);
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                2: begin
                    apply_settings(16'($urandom_range(5000, 1)), CH_W'($urandom_range(2047)),
                                   CH_W'($urandom_range(2047)));
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                default: begin
                    apply_settings(GAP_THR_RST, DIG_HI_RST, DIG_LO_RST);
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            start_count = sent_items;
            while (sent_items - start_count < PHASE_ITEMS) send_sequence();
            // leave framing at position zero and unlocked for the next setting, unless the gap threshold is all ones
            b = 8'($urandom_range(255));
            if (b == START_BYTE) b = 8'hf0;
            send_byte(b, 16'hffff);
        end

        drain();
        if (tracker.errors == 0 && tracker.due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
